/* rtl/matrix4_multiply_accumulate_defines.svh */
// Assertion macros for the checker file of the 4x4 transform accumulator.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef MATRIX4_MULTIPLY_ACCUMULATE_DEFINES_SVH
`define MATRIX4_MULTIPLY_ACCUMULATE_DEFINES_SVH

// consequence holds in the same cycle as the antecedent
`define MMA_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mma assertion failed");

// consequence holds in the cycle after the antecedent
`define MMA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mma assertion failed");

`endif

/* rtl/mma_pkg.sv */
// Shared types and constants of the 4x4 transform accumulator.
// No dependencies; every other module file imports it.
package mma_pkg;

  localparam int DEFAULT_FRAC_BITS   = 16;
  localparam int DEFAULT_QUEUE_DEPTH = 4;

  typedef struct packed {
    logic               kind;
    logic [3:0]         element_index;
    logic signed [31:0] element_value;
  } in_word_t;

  typedef struct packed {
    logic [3:0]         result_index;
    logic signed [31:0] result_value;
    logic               last;
  } out_word_t;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_MULT,
    CMD_IDENT
  } cmd_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [3:0]         idx;
    logic signed [31:0] value;
  } q_entry_t;

endpackage

/* rtl/mma_front.sv */
// Front end: takes input words and classifies them into queue commands.
// Depends on mma_pkg.
module mma_front
  import mma_pkg::*;
(
  input  logic     in_valid,
  output logic     in_stall,
  input  in_word_t in_word,
  input  logic     q_full,
  output logic     push,
  output q_entry_t push_entry
);

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    push_entry.idx   = in_word.element_index;
    push_entry.value = in_word.element_value;
    if (in_word.kind) begin
      push_entry.cmd = CMD_IDENT;
    end else if (in_word.element_index == 4'd15) begin
      push_entry.cmd = CMD_MULT;
    end else begin
      push_entry.cmd = CMD_LOAD;
    end
  end

endmodule

/* rtl/mma_queue.sv */
// Short command queue between the front end and the compute engine.
// Depends on mma_pkg.
module mma_queue
  import mma_pkg::*;
#(
  parameter int DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t push_entry,
  output logic     full,
  output logic     q_valid,
  output q_entry_t head,
  input  logic     pop
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  q_entry_t        slot_r [DEPTH];
  logic [AW-1:0]   rd_ptr_r;
  logic [AW-1:0]   wr_ptr_r;
  logic [CW-1:0]   count_r;

  function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full    = (count_r == CW'(DEPTH));
  assign q_valid = (count_r != '0);
  assign head    = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= bump(wr_ptr_r);
      if (pop)  rd_ptr_r <= bump(rd_ptr_r);
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_entry;
  end

endmodule

/* rtl/mma_back.sv */
// Compute engine: operand store, ping-pong accumulator banks, one shared
// multiply-accumulate unit and the output register. Depends on mma_pkg.
module mma_back
  import mma_pkg::*;
#(
  parameter int FRAC_BITS = DEFAULT_FRAC_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  q_entry_t  head,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  localparam int TERM_W = 64 - FRAC_BITS;
  localparam int SUM_W  = TERM_W + 2;
  localparam logic signed [31:0]      ONE    = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [31:0]      MAX32  = 32'sh7FFFFFFF;
  localparam logic signed [31:0]      MIN32  = 32'sh80000000;
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(MAX32);
  localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(MIN32);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_DRAIN
  } state_t;

  state_t             state_r;
  logic [5:0]         step_r;
  logic               bank_r;
  logic               ident_r;
  logic               mv_r;
  logic               mk0_r;
  logic               mk3_r;
  logic [3:0]         me_r;
  logic signed [63:0] prod_r;
  logic signed [SUM_W-1:0] sum_r;
  logic               out_valid_r;
  out_word_t          out_word_r;
  logic signed [31:0] op_r  [16];
  logic signed [31:0] acc_r [2][16];

  logic [1:0]              k, r, c;
  logic signed [31:0]      a_val, b_val;
  logic                    en, issue, done, finish;
  logic signed [TERM_W-1:0] term;
  logic signed [SUM_W-1:0] total;
  logic signed [31:0]      sat;

  // step = column, row, k from msb to lsb
  assign k = step_r[1:0];
  assign r = step_r[3:2];
  assign c = step_r[5:4];

  // old accumulator reads as identity after reset or an identity word until the next multiply lands
  assign a_val = ident_r ? ((k == r) ? ONE : 32'sd0) : acc_r[bank_r][{k, r}];
  assign b_val = op_r[{c, k}];

  // hold the whole engine while a finished element cannot enter the output register
  assign en     = !(mv_r && mk3_r && out_valid_r && out_stall);
  assign issue  = (state_r == S_ISSUE) && en;
  assign done   = en && mv_r && mk3_r;
  assign finish = done && (me_r == 4'd15);
  assign pop    = (state_r == S_IDLE) && q_valid;

  assign term  = TERM_W'(prod_r >>> FRAC_BITS);
  assign total = (mk0_r ? SUM_W'(0) : sum_r) + SUM_W'(term);

  always_comb begin
    if (total > SAT_HI) begin
      sat = MAX32;
    end else if (total < SAT_LO) begin
      sat = MIN32;
    end else begin
      sat = total[31:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      bank_r      <= 1'b0;
      ident_r     <= 1'b1;
      mv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (done) begin
        out_valid_r             <= 1'b1;
        out_word_r.result_index <= me_r;
        out_word_r.result_value <= sat;
        out_word_r.last         <= (me_r == 4'd15);
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (en) mv_r <= issue;
      case (state_r)
        S_IDLE: begin
          if (pop) begin
            case (head.cmd)
              CMD_IDENT: ident_r <= 1'b1;
              CMD_MULT: begin
                state_r <= S_ISSUE;
                step_r  <= '0;
              end
              default: ;
            endcase
          end
        end
        S_ISSUE: begin
          if (en) begin
            step_r <= step_r + 1'b1;
            if (step_r == 6'd63) state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          // swap banks once the sixteenth element is written
          if (finish) begin
            state_r <= S_IDLE;
            bank_r  <= ~bank_r;
            ident_r <= 1'b0;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= a_val * b_val;
      mk0_r  <= (k == 2'd0);
      mk3_r  <= (k == 2'd3);
      me_r   <= step_r[5:2];
      if (mv_r) sum_r <= total;
    end
    if (pop && head.cmd != CMD_IDENT) op_r[head.idx] <= head.value;
    if (done) acc_r[~bank_r][me_r] <= sat;
  end

endmodule

/* rtl/matrix4_multiply_accumulate.sv */
// Load and identity words pass the queue and are popped by the engine only while it is idle.
// A multiply runs 64 products through one 32x32 multiplier, four per result word, and
// emits the sixteen result words in ascending index order through the output register.
// While a multiply runs no word is popped; the queue fills and then in_stall rises.
// Synchronous active-low reset: accumulator reads as identity, queue empty, operand unset.
module matrix4_multiply_accumulate
  import mma_pkg::*;
#(
  parameter int FRAC_BITS   = DEFAULT_FRAC_BITS,
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  logic     q_full;
  logic     push;
  q_entry_t push_entry;
  logic     q_valid;
  q_entry_t head;
  logic     pop;

  mma_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  mma_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .q_valid    (q_valid),
    .head       (head),
    .pop        (pop)
  );

  mma_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

/* rtl/mma_checker.sv */
// Port-level checker for the 4x4 transform accumulator, bound to the top level.
// Depends on mma_pkg and matrix4_multiply_accumulate_defines.svh.
`include "matrix4_multiply_accumulate_defines.svh"

module mma_checker
  import mma_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_word_t  in_word,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_word
);

  logic [3:0] exp_idx_r;
  logic [3:0] exp_idx_nxt;

  // advance the expected index on every taken result word
  assign exp_idx_nxt = (out_valid && !out_stall) ? exp_idx_r + 1'b1 : exp_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_idx_r <= '0;
    end else begin
      exp_idx_r <= exp_idx_nxt;
    end
  end

  `MMA_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_word))
  `MMA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word))
  `MMA_ASSERT_SAME(a_out_order, out_valid, out_word.result_index == exp_idx_r)
  `MMA_ASSERT_SAME(a_out_last, out_valid, out_word.last == (out_word.result_index == 4'd15))

endmodule

bind matrix4_multiply_accumulate mma_checker u_mma_checker (.*);

/* test/matrix4_multiply_accumulate_test.sv */
// Self-checking testbench for matrix4_multiply_accumulate: operand loads, multiplies and
// identity restores go in; every emitted accumulator word is checked against a local predictor.
// Depends on mma_pkg for the word types and the default fraction width.
module matrix4_multiply_accumulate_test;
  import mma_pkg::*;

  localparam int FRAC = DEFAULT_FRAC_BITS;
  localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC;
  localparam logic signed [31:0] VAL_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] VAL_MIN = 32'sh80000000;
  localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
  localparam logic signed [65:0] SAT_LO = -66'sd2147483648;
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_IDENT = 1'b1;
  localparam logic [3:0] LAST_INDEX = 4'd15;
  localparam int RANDOM_ITEMS = 160;
  localparam int CALM_TAIL = 30;
  localparam int SETTLE_CYCLES = 150;
  localparam int CYCLE_LIMIT = 500000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_word;

  in_word_t pending_words[$];
  out_word_t awaited_elements[$];
  logic signed [31:0] acc_matrix[16];
  logic signed [31:0] rhs_matrix[16];
  int in_gap = 0;
  int out_gap = 0;
  int failures = 0;
  int unsigned cycles = 0;

  matrix4_multiply_accumulate dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_word(in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word(out_word)
  );

  always #1 clk = ~clk;

  function automatic void load_identity();
    for (int i = 0; i < 16; i++) begin
      acc_matrix[i] = (i % 5 == 0) ? ONE : '0;
    end
  endfunction

  // Apply one accepted word to the local matrices and queue the words it produces.
  function automatic void transform_step(input in_word_t w);
    logic signed [31:0] fresh[16];
    logic signed [63:0] lhs;
    logic signed [63:0] rhs;
    logic signed [63:0] prod;
    logic signed [65:0] sum;
    out_word_t elem;
    if (w.kind == KIND_IDENT) begin
      load_identity();
      return;
    end
    rhs_matrix[w.element_index] = w.element_value;
    if (w.element_index != LAST_INDEX) return;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sum = '0;
        for (int k = 0; k < 4; k++) begin
          lhs = acc_matrix[k*4 + r];
          rhs = rhs_matrix[c*4 + k];
          prod = lhs * rhs;
          sum = sum + (prod >>> FRAC);
        end
        if (sum > SAT_HI) fresh[c*4 + r] = VAL_MAX;
        else if (sum < SAT_LO) fresh[c*4 + r] = VAL_MIN;
        else fresh[c*4 + r] = sum[31:0];
      end
    end
    for (int i = 0; i < 16; i++) begin
      acc_matrix[i] = fresh[i];
      elem.result_index = 4'(i);
      elem.result_value = fresh[i];
      elem.last = (i == 15);
      awaited_elements.push_back(elem);
    end
  endfunction

  function automatic void queue_word(input logic kind, input logic [3:0] idx,
                                     input logic signed [31:0] value);
    in_word_t w;
    w.kind = kind;
    w.element_index = idx;
    w.element_value = value;
    pending_words.push_back(w);
  endfunction

  // Mostly values near unity so products stay in range; some full-range and edge values.
  function automatic logic signed [31:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel < 9) return $signed(32'($urandom_range(0, 4*65536))) - 2*65536;
    if (sel < 13) return $signed(32'($urandom_range(0, 65536))) - 32768;
    if (sel < 17) return $signed($urandom);
    case ($urandom_range(0, 5))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2: return -32'sd1;
      3: return ONE;
      4: return -ONE;
      default: return '0;
    endcase
  endfunction

  function automatic void check_element(input out_word_t got);
    out_word_t want;
    if (awaited_elements.size() == 0) begin
      $error("unexpected result word: index %0d value %0d last %0b",
             got.result_index, got.result_value, got.last);
      failures++;
      return;
    end
    want = awaited_elements.pop_front();
    if (got.result_index !== want.result_index) begin
      $error("result_index: expected %0d, got %0d", want.result_index, got.result_index);
      failures++;
    end
    if (got.result_value !== want.result_value) begin
      $error("result_value: expected %0d, got %0d", want.result_value, got.result_value);
      failures++;
    end
    if (got.last !== want.last) begin
      $error("last: expected %0b, got %0b", want.last, got.last);
      failures++;
    end
  endfunction

  // Driver: present queued words, with random gaps until the tail of the run.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_word <= '0;
      in_gap <= 0;
    end else begin
      if (in_valid && !in_stall) transform_step(in_word);
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          in_valid <= 1'b1;
          in_word <= pending_words.pop_front();
          if (pending_words.size() >= CALM_TAIL && $urandom_range(0, 5) == 0)
            in_gap <= $urandom_range(1, 15);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check accepted result words, stall in random bursts until the tail.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_gap <= 0;
    end else begin
      if (out_valid && !out_stall) check_element(out_word);
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall <= 1'b1;
      end else if (pending_words.size() >= CALM_TAIL && $urandom_range(0, 9) == 0) begin
        out_gap <= $urandom_range(0, 14);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int unsigned sent;
    int unsigned n;
    logic [3:0] order[15];
    logic [3:0] swap;
    int unsigned j;

    load_identity();
    for (int i = 0; i < 16; i++) rhs_matrix[i] = '0;

    // Directed: full operand load with edge values; identity times operand is exact.
    queue_word(KIND_LOAD, 4'd0, VAL_MAX);
    queue_word(KIND_LOAD, 4'd1, VAL_MIN);
    queue_word(KIND_LOAD, 4'd2, '0);
    queue_word(KIND_LOAD, 4'd3, -32'sd1);
    queue_word(KIND_LOAD, 4'd4, 32'sd1);
    queue_word(KIND_LOAD, 4'd5, ONE);
    queue_word(KIND_LOAD, 4'd6, -ONE);
    queue_word(KIND_LOAD, 4'd7, 32'sh55555555);
    queue_word(KIND_LOAD, 4'd8, 32'shaaaaaaaa);
    queue_word(KIND_LOAD, 4'd9, ONE >>> 1);
    queue_word(KIND_LOAD, 4'd10, ONE);
    queue_word(KIND_LOAD, 4'd11, 32'sh00030000);
    queue_word(KIND_LOAD, 4'd12, -32'sh00020000);
    queue_word(KIND_LOAD, 4'd13, 32'sh0000ffff);
    queue_word(KIND_LOAD, 4'd14, 32'sh7fff0000);
    queue_word(KIND_LOAD, LAST_INDEX, ONE);
    // Reuse the held operand: large values saturate both ways.
    queue_word(KIND_LOAD, LAST_INDEX, -ONE);
    // Identity restore ignores its index and value.
    queue_word(KIND_IDENT, LAST_INDEX, VAL_MAX);
    queue_word(KIND_LOAD, LAST_INDEX, VAL_MIN);
    // Partial load, then multiply again.
    queue_word(KIND_LOAD, 4'd5, VAL_MAX);
    queue_word(KIND_LOAD, LAST_INDEX, ONE);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          if ($urandom_range(0, 3) == 0) begin
            queue_word(KIND_IDENT, 4'($urandom), $signed($urandom));
            sent++;
          end
          for (int i = 0; i < 15; i++) order[i] = 4'(i);
          if ($urandom_range(0, 1) == 1) begin
            for (int i = 14; i > 0; i--) begin
              j = $urandom_range(0, i);
              swap = order[i];
              order[i] = order[j];
              order[j] = swap;
            end
          end
          for (int i = 0; i < 15; i++) queue_word(KIND_LOAD, order[i], pick_value());
          queue_word(KIND_LOAD, LAST_INDEX, pick_value());
          sent += 16;
        end
        6: begin
          queue_word(KIND_LOAD, LAST_INDEX, pick_value());
          sent++;
        end
        7: begin
          n = $urandom_range(1, 5);
          for (int i = 0; i < n; i++) queue_word(KIND_LOAD, 4'($urandom_range(0, 14)), pick_value());
          sent += n;
        end
        8: begin
          queue_word(KIND_IDENT, 4'($urandom), $signed($urandom));
          sent++;
        end
        default: begin
          // Abandoned reload: some elements written, no multiply.
          n = $urandom_range(1, 14);
          for (int i = 0; i < n; i++) queue_word(KIND_LOAD, 4'(i), pick_value());
          sent += n;
        end
      endcase
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_words.size() > 0 || in_valid || awaited_elements.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (awaited_elements.size() > 0) begin
      $error("%0d result words never arrived", awaited_elements.size());
      failures++;
    end
    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
